// ===== hw/rtl/periodic_timer_table_unit_defines.svh =====
// assertion macros shared by the timer table checker
`ifndef PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH

// consequence must hold in the same cycle as the antecedent
`define PTT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ptt_pkg.sv =====
// types and constants shared by the timer table modules
package ptt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ID_W      = 16;
    localparam int PER_W     = 31;
    localparam int TICK_W    = 16;
    localparam int REQ_W     = 3;
    localparam int DIV_STEPS = PER_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(100);
    localparam logic [PER_W-1:0]  PER_MAX    = {PER_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 3'd0,
        REQ_CREATE  = 3'd1,
        REQ_DELETE  = 3'd2,
        REQ_RESTART = 3'd3,
        REQ_CHANGE  = 3'd4
    } t_req;

    typedef struct packed {
        logic              start;
        logic [PER_W-1:0]  num;
        logic [TICK_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [PER_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== hw/rtl/periodic_timer_table_unit.sv =====
// tick: walks the slots, running a reload division for each periodic expiry
// create: one division; delete: a search of up to 16 slots
// restart: search plus one division; change period: search plus one or two divisions
// shared 31-step divider; the walk moves one slot per cycle but stalls at an expiry
// one transaction in flight; the next is taken once the sequencer is idle again
// synchronous active-low reset frees every slot, clears the id counter, tick_ms to 100
module periodic_timer_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // target_id[15:0], period_ms[46:16], reload[47]
    input  logic [2:0]  i_s_axis_tuser,   // req_type[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // result_id[15:0]
    output logic [1:0]  o_m_axis_tuser,   // status[0], fired[1]
    output logic        o_m_axis_tlast
);

    localparam int NS    = ptt_pkg::NUM_SLOTS;
    localparam int IW    = ptt_pkg::IDX_W;
    localparam int PW    = ptt_pkg::PER_W;
    localparam int DW    = ptt_pkg::ID_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_TICK_DIV,
        S_TICK_END,
        S_CREATE_DIV,
        S_FIND,
        S_RESTART_DIV,
        S_CP_DIV1,
        S_CP_DIV2,
        S_EMIT
    } t_state;

    // control
    t_state                     r_state, n_state;
    logic [IW-1:0]              r_idx, n_idx;
    logic [NS-1:0]              r_used, n_used;
    logic [DW-1:0]              r_id_ctr, n_id_ctr;
    logic [ptt_pkg::TICK_W-1:0] r_tick;
    logic                       r_pend_valid, n_pend_valid;
    logic                       r_out_valid, n_out_valid;
    logic                       r_div_start, n_div_start;

    // payload
    ptt_pkg::t_req              r_req, n_req;
    logic [DW-1:0]              r_tid, n_tid;
    logic [PW-1:0]              r_per, n_per;
    logic                       r_rel, n_rel;
    logic                       r_neg, n_neg;
    logic [DW-1:0]              r_pend_id, n_pend_id;
    logic [DW-1:0]              r_out_id, n_out_id;
    logic                       r_out_status, n_out_status;
    logic                       r_out_fired, n_out_fired;
    logic                       r_out_last, n_out_last;
    logic                       r_res_status, n_res_status;
    logic [DW-1:0]              r_res_id, n_res_id;
    logic [PW-1:0]              r_div_num, n_div_num;

    // slot store
    logic [DW-1:0]              r_slot_id  [NS];
    logic                       r_slot_rel [NS];
    logic [PW-1:0]              r_slot_per [NS];
    logic [PW-1:0]              r_slot_cnt [NS];

    logic                       w_create;
    logic                       w_cnt_en;
    logic [PW-1:0]              w_cnt_val;
    logic                       w_per_en;

    logic                       s_accept;
    logic                       out_free;
    logic [ptt_pkg::TICK_W-1:0] divisor;
    logic                       free_found;
    logic [IW-1:0]              free_idx;
    logic [DW-1:0]              next_id;
    logic [DW-1:0]              cur_id;
    logic                       cur_rel;
    logic [PW-1:0]              cur_per;
    logic [PW-1:0]              cur_cnt;
    logic [PW:0]                cp_sum;
    logic                       last_idx;

    ptt_pkg::t_div_req          div_req;
    ptt_pkg::t_div_rsp          div_rsp;

    ptt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign divisor       = (r_tick == '0) ? ptt_pkg::TICK_W'(1) : r_tick;
    assign div_req.start = r_div_start;
    assign div_req.num   = r_div_num;
    assign div_req.den   = divisor;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign cur_id   = r_slot_id[r_idx];
    assign cur_rel  = r_slot_rel[r_idx];
    assign cur_per  = r_slot_per[r_idx];
    assign cur_cnt  = r_slot_cnt[r_idx];
    assign last_idx = (r_idx == IW'(NS - 1));
    assign next_id  = (r_id_ctr == {DW{1'b1}}) ? DW'(1) : r_id_ctr + DW'(1);
    assign cp_sum   = {1'b0, cur_cnt} + {1'b0, div_rsp.quot};

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_used       = r_used;
        n_id_ctr     = r_id_ctr;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_out_valid  = r_out_valid;
        n_out_id     = r_out_id;
        n_out_status = r_out_status;
        n_out_fired  = r_out_fired;
        n_out_last   = r_out_last;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_div_start  = 1'b0;
        n_div_num    = r_div_num;
        n_req        = r_req;
        n_tid        = r_tid;
        n_per        = r_per;
        n_rel        = r_rel;
        n_neg        = r_neg;
        w_create     = 1'b0;
        w_cnt_en     = 1'b0;
        w_cnt_val    = '0;
        w_per_en     = 1'b0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_req = ptt_pkg::t_req'(i_s_axis_tuser);
                    n_tid = i_s_axis_tdata[15:0];
                    n_per = i_s_axis_tdata[46:16];
                    n_rel = i_s_axis_tdata[47];
                    n_idx = '0;
                    unique case (i_s_axis_tuser)
                        ptt_pkg::REQ_TICK: begin
                            n_pend_valid = 1'b0;
                            n_state      = S_TICK;
                        end
                        ptt_pkg::REQ_CREATE: begin
                            if (free_found) begin
                                n_idx       = free_idx;
                                n_div_num   = i_s_axis_tdata[46:16];
                                n_div_start = 1'b1;
                                n_state     = S_CREATE_DIV;
                            end else begin
                                n_res_status = 1'b1;
                                n_res_id     = '0;
                                n_state      = S_EMIT;
                            end
                        end
                        ptt_pkg::REQ_DELETE,
                        ptt_pkg::REQ_RESTART,
                        ptt_pkg::REQ_CHANGE: begin
                            n_state = S_FIND;
                        end
                        default: ;  // unknown request: dropped without a result
                    endcase
                end
            end

            S_TICK: begin
                if (r_used[r_idx] && cur_cnt == '0) begin
                    // an earlier expiry is held back until we know it is not the last
                    if (!r_pend_valid || out_free) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_id     = r_pend_id;
                            n_out_status = 1'b0;
                            n_out_fired  = 1'b1;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_id    = cur_id;
                        if (cur_rel) begin
                            n_div_num   = cur_per;
                            n_div_start = 1'b1;
                            n_state     = S_TICK_DIV;
                        end else begin
                            n_used[r_idx] = 1'b0;
                            n_idx         = r_idx + IW'(1);
                            if (last_idx) n_state = S_TICK_END;
                        end
                    end
                end else begin
                    if (r_used[r_idx]) begin
                        w_cnt_en  = 1'b1;
                        w_cnt_val = cur_cnt - PW'(1);
                    end
                    n_idx = r_idx + IW'(1);
                    if (last_idx) n_state = S_TICK_END;
                end
            end

            S_TICK_DIV: begin
                if (div_rsp.done) begin
                    // reloaded count is decremented in the same tick
                    w_cnt_en  = 1'b1;
                    w_cnt_val = (div_rsp.quot == '0) ? '0 : div_rsp.quot - PW'(1);
                    n_idx     = r_idx + IW'(1);
                    n_state   = last_idx ? S_TICK_END : S_TICK;
                end
            end

            S_TICK_END: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = r_pend_id;
                    n_out_status = 1'b0;
                    n_out_fired  = 1'b1;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            S_CREATE_DIV: begin
                if (div_rsp.done) begin
                    w_create      = 1'b1;
                    n_used[r_idx] = 1'b1;
                    n_id_ctr      = next_id;
                    n_res_status  = 1'b0;
                    n_res_id      = next_id;
                    n_state       = S_EMIT;
                end
            end

            S_FIND: begin
                n_res_status = 1'b0;
                n_res_id     = '0;
                if (r_used[r_idx] && cur_id == r_tid) begin
                    unique case (r_req)
                        ptt_pkg::REQ_DELETE: begin
                            n_used[r_idx] = 1'b0;
                            n_state       = S_EMIT;
                        end
                        ptt_pkg::REQ_RESTART: begin
                            n_div_num   = cur_per;
                            n_div_start = 1'b1;
                            n_state     = S_RESTART_DIV;
                        end
                        default: begin
                            n_div_num   = r_per;
                            n_div_start = 1'b1;
                            n_state     = S_CP_DIV1;
                        end
                    endcase
                end else if (last_idx) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            S_RESTART_DIV: begin
                if (div_rsp.done) begin
                    w_cnt_en  = 1'b1;
                    w_cnt_val = div_rsp.quot;
                    n_state   = S_EMIT;
                end
            end

            S_CP_DIV1: begin
                if (div_rsp.done) begin
                    if (cur_cnt >= div_rsp.quot) begin
                        w_cnt_en  = 1'b1;
                        w_cnt_val = div_rsp.quot;
                        w_per_en  = 1'b1;
                        n_state   = S_EMIT;
                    end else begin
                        // magnitude of the period change, sign kept aside
                        n_neg       = (r_per < cur_per);
                        n_div_num   = (r_per < cur_per) ? cur_per - r_per : r_per - cur_per;
                        n_div_start = 1'b1;
                        n_state     = S_CP_DIV2;
                    end
                end
            end

            S_CP_DIV2: begin
                if (div_rsp.done) begin
                    w_cnt_en = 1'b1;
                    w_per_en = 1'b1;
                    if (r_neg) begin
                        w_cnt_val = (cur_cnt < div_rsp.quot) ? '0 : cur_cnt - div_rsp.quot;
                    end else begin
                        w_cnt_val = cp_sum[PW] ? ptt_pkg::PER_MAX : cp_sum[PW-1:0];
                    end
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = r_res_id;
                    n_out_status = r_res_status;
                    n_out_fired  = 1'b0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_used       <= '0;
            r_id_ctr     <= '0;
            r_tick       <= ptt_pkg::TICK_RESET;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_div_start  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_used       <= n_used;
            r_id_ctr     <= n_id_ctr;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_div_start  <= n_div_start;
            if (i_cfg_we) begin
                r_tick <= i_cfg_wdata;
            end
        end
        r_req        <= n_req;
        r_tid        <= n_tid;
        r_per        <= n_per;
        r_rel        <= n_rel;
        r_neg        <= n_neg;
        r_pend_id    <= n_pend_id;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
        r_out_fired  <= n_out_fired;
        r_out_last   <= n_out_last;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_div_num    <= n_div_num;
    end

    // slot store, at most one entry written per cycle
    always_ff @(posedge i_clk) begin
        if (w_create) begin
            r_slot_id[r_idx]  <= next_id;
            r_slot_rel[r_idx] <= r_rel;
            r_slot_per[r_idx] <= r_per;
            r_slot_cnt[r_idx] <= div_rsp.quot;
        end
        if (w_cnt_en) begin
            r_slot_cnt[r_idx] <= w_cnt_val;
        end
        if (w_per_en) begin
            r_slot_per[r_idx] <= r_per;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_id;
    assign o_m_axis_tuser  = {r_out_fired, r_out_status};
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== hw/rtl/ptt_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module ptt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptt_pkg::t_div_req i_req,
    output ptt_pkg::t_div_rsp o_rsp
);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } t_dstate;

    t_dstate                          r_state;
    logic                             r_done;
    logic [ptt_pkg::DCNT_W-1:0]       r_cnt;
    logic [ptt_pkg::PER_W-1:0]        r_num;
    logic [ptt_pkg::TICK_W-1:0]       r_rem;
    logic [ptt_pkg::TICK_W-1:0]       r_den;

    logic [ptt_pkg::TICK_W:0]         trial;
    logic [ptt_pkg::TICK_W:0]         diff;
    logic                             ge;

    assign trial = {r_rem, r_num[ptt_pkg::PER_W-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_num   <= i_req.num;
                        r_den   <= i_req.den;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    // quotient bits shift in where the dividend bits leave
                    r_num <= {r_num[ptt_pkg::PER_W-2:0], ge};
                    r_rem <= ge ? diff[ptt_pkg::TICK_W-1:0] : trial[ptt_pkg::TICK_W-1:0];
                    if (r_cnt == ptt_pkg::DCNT_W'(ptt_pkg::DIV_STEPS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_cnt <= r_cnt + ptt_pkg::DCNT_W'(1);
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

// ===== hw/rtl/ptt_checker.sv =====
// port-level checker for the timer table, bound to the top level
`include "periodic_timer_table_unit_defines.svh"

module ptt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [2:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // a stalled result stays put
    `PTT_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "result changed while stalled")

    // a full report is a lone result with no id and no expiry
    `PTT_ASSERT_SAME(a_full_form, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tlast && !o_m_axis_tuser[1] && o_m_axis_tdata == 16'd0, "malformed full report")

    // an expiry always names a nonzero id with a clear status
    `PTT_ASSERT_SAME(a_fired_id, o_m_axis_tvalid && o_m_axis_tuser[1], !o_m_axis_tuser[0] && o_m_axis_tdata != 16'd0, "expiry with zero id or error status")

    // a known request keeps the block busy in the following cycle
    `PTT_ASSERT_NEXT(a_busy_after, i_s_axis_tvalid && o_s_axis_tready && (!i_s_axis_tuser[2] || i_s_axis_tuser[1:0] == 2'd0), !o_s_axis_tready, "ready straight after a request")

endmodule

bind periodic_timer_table_unit ptt_checker u_ptt_checker (.*);
